// ----- rtl/cks_pkg.sv -----
// ---------------------------------------------------------------------------
// cks_pkg: shared types and constants of the credential key slot table
// command and status codes, sequencer states, store request bundle, defaults
// ---------------------------------------------------------------------------
package cks_pkg;

    localparam int DEF_CRED_SLOTS   = 16;
    localparam int DEF_ISSUER_SLOTS = 4;
    localparam int DEF_KEY_BITS     = 64;

    // one byte of address covers every bank of up to 256 slots
    localparam int MAX_SLOT_AW = 8;

    localparam int KEY_W      = 64;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 4;
    localparam int M_DATA_W   = 80;
    localparam int M_USER_W   = 2;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_MEMORY = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_RDADDR,
        S_RDDATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   rd_en;
        logic                   bank;
        logic [MAX_SLOT_AW-1:0] rd_addr;
        logic                   we;
        logic [MAX_SLOT_AW-1:0] waddr;
    } store_req_t;

endpackage

// ----- rtl/cks_store.sv -----
// ---------------------------------------------------------------------------
// cks_store: key memories of both banks with the shared tag comparator
// one registered read port, one write port, match against the request tag
// ---------------------------------------------------------------------------
module cks_store #(
    parameter int CRED_SLOTS   = cks_pkg::DEF_CRED_SLOTS,
    parameter int ISSUER_SLOTS = cks_pkg::DEF_ISSUER_SLOTS,
    parameter int KEY_BITS     = cks_pkg::DEF_KEY_BITS
) (
    input  logic                clk,
    input  cks_pkg::store_req_t req,
    input  logic [KEY_BITS-1:0] wr_key,
    input  logic [KEY_BITS-1:0] cmp_key,
    output logic [KEY_BITS-1:0] rd_key,
    output logic                match
);
    import cks_pkg::*;

    localparam int CA_W = (CRED_SLOTS > 1) ? $clog2(CRED_SLOTS) : 1;
    localparam int IA_W = (ISSUER_SLOTS > 1) ? $clog2(ISSUER_SLOTS) : 1;

    logic [KEY_BITS-1:0] cred_mem [CRED_SLOTS];
    logic [KEY_BITS-1:0] issuer_mem [ISSUER_SLOTS];
    logic [KEY_BITS-1:0] cred_rd_reg;
    logic [KEY_BITS-1:0] issuer_rd_reg;
    logic                bank_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.we && !req.bank)
        begin
            cred_mem[req.waddr[CA_W-1:0]] <= wr_key;
        end
        if (req.rd_en && !req.bank)
        begin
            cred_rd_reg <= cred_mem[req.rd_addr[CA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we && req.bank)
        begin
            issuer_mem[req.waddr[IA_W-1:0]] <= wr_key;
        end
        if (req.rd_en && req.bank)
        begin
            issuer_rd_reg <= issuer_mem[req.rd_addr[IA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            bank_rd_reg <= req.bank;
        end
    end

    assign rd_key = bank_rd_reg ? issuer_rd_reg : cred_rd_reg;
    // the single comparator every scan step goes through
    assign match  = (rd_key == cmp_key);

endmodule

// ----- rtl/credential_key_slot_table.sv -----
// lookup, add and remove scan their bank (lookup always the credential bank) slot by
//   slot through one comparator and then resolve, stopping the scan early when a slot
//   matches
// read goes through an address and a data state; clear and unknown commands skip both
// throughput: one command at a time, next request taken once the result is accepted
// reset clears valid bits and occupancy counts at once; key memories are not cleared
// ---------------------------------------------------------------------------
// credential_key_slot_table: two-bank key slot table with sequential scan
// lookup, add, remove, clear and read commands over credential and issuer keys
// ---------------------------------------------------------------------------
module credential_key_slot_table #(
    parameter int CRED_SLOTS   = cks_pkg::DEF_CRED_SLOTS,
    parameter int ISSUER_SLOTS = cks_pkg::DEF_ISSUER_SLOTS,
    parameter int KEY_BITS     = cks_pkg::DEF_KEY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_value[63:0], slot_given[64], slot_index[68:65], zero pad
    input  logic [cks_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd[2:0], bank[3]
    input  logic [cks_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], slot_out[4:1], key_out[68:5], key_count[73:69], zero pad
    output logic [cks_pkg::M_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [cks_pkg::M_USER_W-1:0]  m_tuser
);
    import cks_pkg::*;

    localparam int CA_W  = (CRED_SLOTS > 1) ? $clog2(CRED_SLOTS) : 1;
    localparam int IA_W  = (ISSUER_SLOTS > 1) ? $clog2(ISSUER_SLOTS) : 1;
    localparam int IDX_W = (CA_W > IA_W) ? CA_W : IA_W;
    localparam int CC_W  = $clog2(CRED_SLOTS + 1);
    localparam int IC_W  = $clog2(ISSUER_SLOTS + 1);
    localparam int CNT_W = (CC_W > IC_W) ? CC_W : IC_W;

    state_t state_reg, state_next;

    cmd_t                    cmd_reg, cmd_next;
    logic                    bank_reg, bank_next;
    logic [KEY_BITS-1:0]     tag_reg, tag_next;
    logic                    given_reg, given_next;
    logic [SLOT_W-1:0]       sidx_reg, sidx_next;

    logic [IDX_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                    issue_live_reg, issue_live_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    cmp_live_reg, cmp_live_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    logic [CRED_SLOTS-1:0]   cred_valid_reg, cred_valid_next;
    logic [ISSUER_SLOTS-1:0] issuer_valid_reg, issuer_valid_next;
    logic [CC_W-1:0]         cred_count_reg, cred_count_next;
    logic [IC_W-1:0]         issuer_count_reg, issuer_count_next;

    status_t                 res_status_reg, res_status_next;
    logic                    res_found_reg, res_found_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [COUNT_W-1:0]      res_count_reg, res_count_next;

    store_req_t              store_req;
    logic [KEY_BITS-1:0]     rd_key;
    logic                    match;

    cmd_t                    in_cmd;
    logic                    in_bank;
    logic [KEY_W-1:0]        in_key;
    logic                    in_given;
    logic [SLOT_W-1:0]       in_sidx;

    logic                    cmp_valid;
    logic [IDX_W-1:0]        n_last;
    logic                    at_last;
    logic [CNT_W-1:0]        cur_count;
    logic                    bank_full;
    logic [IDX_W-1:0]        add_pos;
    logic                    add_pos_ok;
    logic                    add_pos_valid;
    logic                    rd_valid;

    assign in_cmd   = cmd_t'(s_tuser[2:0]);
    assign in_bank  = s_tuser[3];
    assign in_key   = s_tdata[63:0];
    assign in_given = s_tdata[64];
    assign in_sidx  = s_tdata[68:65];

    cks_store #(
        .CRED_SLOTS   (CRED_SLOTS),
        .ISSUER_SLOTS (ISSUER_SLOTS),
        .KEY_BITS     (KEY_BITS)
    ) u_store (
        .clk     (clk),
        .req     (store_req),
        .wr_key  (tag_reg),
        .cmp_key (tag_reg),
        .rd_key  (rd_key),
        .match   (match)
    );

    // scan and slot bookkeeping for the addressed bank
    always_comb
    begin
        cmp_valid = bank_reg ? issuer_valid_reg[cmp_idx_reg[IA_W-1:0]]
                             : cred_valid_reg[cmp_idx_reg[CA_W-1:0]];
        n_last    = bank_reg ? IDX_W'(ISSUER_SLOTS - 1) : IDX_W'(CRED_SLOTS - 1);
        at_last   = (cmp_idx_reg == n_last);
        cur_count = bank_reg ? CNT_W'(issuer_count_reg) : CNT_W'(cred_count_reg);
        bank_full = bank_reg ? (cur_count >= CNT_W'(ISSUER_SLOTS))
                             : (cur_count >= CNT_W'(CRED_SLOTS));
        add_pos   = given_reg ? IDX_W'(sidx_reg) : free_idx_reg;
        // a free slot always exists when the bank is not full
        add_pos_ok = !given_reg
                     || (bank_reg ? (32'(sidx_reg) < 32'(ISSUER_SLOTS))
                                  : (32'(sidx_reg) < 32'(CRED_SLOTS)));
        add_pos_valid = bank_reg ? issuer_valid_reg[add_pos[IA_W-1:0]]
                                 : cred_valid_reg[add_pos[CA_W-1:0]];
        rd_valid = (32'(sidx_reg) < 32'(CRED_SLOTS))
                   && cred_valid_reg[CA_W'(sidx_reg)];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_cmd)
                        CMD_LOOKUP, CMD_ADD, CMD_REMOVE: state_next = S_SCAN;
                        CMD_READ:                        state_next = S_RDADDR;
                        default:                         state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cmp_live_reg && ((cmp_valid && match) || at_last))
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE: state_next = S_DONE;
            S_RDADDR:  state_next = S_RDDATA;
            S_RDDATA:  state_next = S_DONE;
            S_DONE:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next          = cmd_reg;
        bank_next         = bank_reg;
        tag_next          = tag_reg;
        given_next        = given_reg;
        sidx_next         = sidx_reg;
        issue_idx_next    = issue_idx_reg;
        issue_live_next   = issue_live_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_live_next     = cmp_live_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        cred_valid_next   = cred_valid_reg;
        issuer_valid_next = issuer_valid_reg;
        cred_count_next   = cred_count_reg;
        issuer_count_next = issuer_count_reg;
        res_status_next   = res_status_reg;
        res_found_next    = res_found_reg;
        res_slot_next     = res_slot_reg;
        res_key_next      = res_key_reg;
        res_count_next    = res_count_reg;

        store_req         = '0;
        store_req.bank    = bank_reg;
        store_req.rd_addr = MAX_SLOT_AW'(issue_idx_reg);
        store_req.waddr   = MAX_SLOT_AW'(add_pos);

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next        = in_cmd;
                    bank_next       = (in_cmd == CMD_LOOKUP) ? 1'b0 : in_bank;
                    tag_next        = in_key[KEY_BITS-1:0];
                    given_next      = in_given;
                    sidx_next       = in_sidx;
                    issue_idx_next  = '0;
                    issue_live_next = 1'b1;
                    cmp_live_next   = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_slot_next   = '0;
                    res_key_next    = '0;
                    res_count_next  = COUNT_W'(cred_count_reg);
                    case (in_cmd)
                        CMD_CLEAR:
                        begin
                            cred_valid_next   = '0;
                            issuer_valid_next = '0;
                            cred_count_next   = '0;
                            issuer_count_next = '0;
                            res_count_next    = '0;
                        end
                        CMD_LOOKUP, CMD_ADD, CMD_REMOVE, CMD_READ:
                        begin
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue stage: one slot read per cycle
                store_req.rd_en = issue_live_reg;
                if (issue_live_reg)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    if (issue_idx_reg == n_last)
                    begin
                        issue_live_next = 1'b0;
                    end
                end
                cmp_live_next = issue_live_reg;
                cmp_idx_next  = issue_idx_reg;
                // compare stage: lowest valid match wins, lowest empty slot remembered
                if (cmp_live_reg)
                begin
                    if (cmp_valid && match)
                    begin
                        hit_next        = 1'b1;
                        hit_idx_next    = cmp_idx_reg;
                        issue_live_next = 1'b0;
                        cmp_live_next   = 1'b0;
                    end
                    else if (!cmp_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (at_last)
                    begin
                        issue_live_next = 1'b0;
                        cmp_live_next   = 1'b0;
                    end
                end
            end

            S_RESOLVE:
            begin
                res_count_next = COUNT_W'(cur_count);
                case (cmd_reg)
                    CMD_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            res_found_next = 1'b1;
                            res_slot_next  = SLOT_W'(hit_idx_reg);
                            res_key_next   = KEY_W'(tag_reg);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_slot_next = SLOT_W'(hit_idx_reg);
                        end
                        else if (bank_full || !add_pos_ok)
                        begin
                            res_status_next = ST_NO_MEMORY;
                        end
                        else
                        begin
                            store_req.we  = 1'b1;
                            res_slot_next = SLOT_W'(add_pos);
                            // overwriting an occupied slot keeps the count
                            if (!add_pos_valid)
                            begin
                                res_count_next = COUNT_W'(cur_count + 1'b1);
                            end
                            if (bank_reg)
                            begin
                                issuer_valid_next[add_pos[IA_W-1:0]] = 1'b1;
                                if (!add_pos_valid)
                                begin
                                    issuer_count_next = issuer_count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cred_valid_next[add_pos[CA_W-1:0]] = 1'b1;
                                if (!add_pos_valid)
                                begin
                                    cred_count_next = cred_count_reg + 1'b1;
                                end
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            res_slot_next = SLOT_W'(hit_idx_reg);
                            if (cur_count != '0)
                            begin
                                res_count_next = COUNT_W'(cur_count - 1'b1);
                            end
                            if (bank_reg)
                            begin
                                issuer_valid_next[hit_idx_reg[IA_W-1:0]] = 1'b0;
                                if (issuer_count_reg != '0)
                                begin
                                    issuer_count_next = issuer_count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                cred_valid_next[hit_idx_reg[CA_W-1:0]] = 1'b0;
                                if (cred_count_reg != '0)
                                begin
                                    cred_count_next = cred_count_reg - 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_RDADDR:
            begin
                store_req.rd_en   = 1'b1;
                store_req.bank    = 1'b0;
                store_req.rd_addr = MAX_SLOT_AW'(sidx_reg);
            end

            S_RDDATA:
            begin
                if (rd_valid)
                begin
                    res_key_next  = KEY_W'(rd_key);
                    res_slot_next = sidx_reg;
                end
                else
                begin
                    res_status_next = ST_INVALID;
                end
            end

            S_DONE:
            begin
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_live_reg   <= 1'b0;
            cmp_live_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            cred_valid_reg   <= '0;
            issuer_valid_reg <= '0;
            cred_count_reg   <= '0;
            issuer_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_live_reg   <= issue_live_next;
            cmp_live_reg     <= cmp_live_next;
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            cred_valid_reg   <= cred_valid_next;
            issuer_valid_reg <= issuer_valid_next;
            cred_count_reg   <= cred_count_next;
            issuer_count_reg <= issuer_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        bank_reg       <= bank_next;
        tag_reg        <= tag_next;
        given_reg      <= given_next;
        sidx_reg       <= sidx_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_slot_reg   <= res_slot_next;
        res_key_reg    <= res_key_next;
        res_count_reg  <= res_count_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {6'b0, res_count_reg, res_key_reg, res_slot_reg, res_found_reg};
    assign m_tuser  = res_status_reg;

endmodule

// ----- rtl/cks_checker.sv -----
// ---------------------------------------------------------------------------
// cks_checker: port-level checks of the credential key slot table
// one command in flight at a time, result flags consistent with status
// ---------------------------------------------------------------------------
module cks_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [cks_pkg::S_DATA_W-1:0] s_tdata,
    input logic [cks_pkg::S_USER_W-1:0] s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cks_pkg::M_DATA_W-1:0] m_tdata,
    input logic [cks_pkg::M_USER_W-1:0] m_tuser
);
    import cks_pkg::*;

    // a request is never taken while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while result pending");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after request");

    a_found_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == ST_OK))
        else $error("found flag with non-ok status");

    a_miss_has_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_NOT_FOUND) |-> (m_tdata[68:0] == '0))
        else $error("not found result carries slot or key");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind credential_key_slot_table cks_checker u_cks_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
